// ----- design/lkvc_pkg.sv -----
`timescale 1ns / 1ps

package lkvc_pkg;

    // Field widths fixed by the port definition
    localparam int CMD_W = 2;
    localparam int CAP_W = 4;
    localparam int OCC_W = 4;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // Operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic update;   // cells take their next contents this cycle
        logic evict;    // oldest entry leaves the row
        logic hit;      // a matching entry leaves its slot
    } cell_ctrl_t;

endpackage

// ----- design/lkvc_if.sv -----
`timescale 1ns / 1ps

// Request channel: one operation per word
interface lkvc_in_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
);
    logic                      valid;
    logic                      ready;
    logic [lkvc_pkg::CMD_W-1:0] cmd;
    logic [KEY_BITS-1:0]       key;
    logic [VALUE_BITS-1:0]     value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

// Result channel: one word per operation
interface lkvc_out_if #(
    parameter int VALUE_BITS = 64
);
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [VALUE_BITS-1:0]      read_value;
    logic [lkvc_pkg::OCC_W-1:0] occupancy;

    modport source (output valid, output hit, output read_value, output occupancy,
                    input ready);
    modport sink   (input valid, input hit, input read_value, input occupancy,
                    output ready);
endinterface

// Capacity register write channel
interface lkvc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lkvc_pkg::CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/lkvc_cell.sv -----
`timescale 1ns / 1ps

// One slot of the recency row: holds a key/value pair, compares it against
// the lookup key and moves down by zero, one or two places on an update.
module lkvc_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                    clk,
    input  lkvc_pkg::cell_ctrl_t    ctrl,
    input  logic                    occupied,
    input  logic                    load,
    input  logic [KEY_BITS-1:0]     lookup_key,
    input  logic [VALUE_BITS-1:0]   new_value,
    input  logic [KEY_BITS-1:0]     up1_key,
    input  logic [VALUE_BITS-1:0]   up1_value,
    input  logic [KEY_BITS-1:0]     up2_key,
    input  logic [VALUE_BITS-1:0]   up2_value,
    input  logic                    seen_in,
    input  logic                    seen_up,
    input  logic [VALUE_BITS-1:0]   rv_in,
    output logic                    seen_out,
    output logic [VALUE_BITS-1:0]   rv_out,
    output logic [KEY_BITS-1:0]     key_q,
    output logic [VALUE_BITS-1:0]   value_q
);
    import lkvc_pkg::*;

    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;
    logic                  match;
    logic                  gap_below;
    logic                  sh1;
    logic                  sh2;

    // compare and pass the prefix-hit and read data along the row
    assign match    = occupied && (key_reg == lookup_key);
    assign seen_out = seen_in | match;
    assign rv_out   = rv_in | (match ? val_reg : '0);

    // the removed hit lies at or below the source slot of this cell
    assign gap_below = ctrl.hit && (ctrl.evict ? seen_up : seen_out);
    assign sh1       = ctrl.evict ^ gap_below;
    assign sh2       = ctrl.evict & gap_below;

    // next contents: new pair, the word one or two slots up, or the current pair
    always_comb
    begin
        if (load)
        begin
            key_next = lookup_key;
            val_next = new_value;
        end
        else if (sh2)
        begin
            key_next = up2_key;
            val_next = up2_value;
        end
        else if (sh1)
        begin
            key_next = up1_key;
            val_next = up1_value;
        end
        else
        begin
            key_next = key_reg;
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            key_reg <= key_next;
            val_reg <= val_next;
        end
    end

    assign key_q   = key_reg;
    assign value_q = val_reg;

endmodule

// ----- design/lru_key_value_cache_unit.sv -----
`timescale 1ns / 1ps
// A request is taken in the idle state and registered; in the execute state the
// row of cells compares, compacts and loads once the output register is free or
// being emptied, and the result word is registered. A new request is taken only
// after the previous one has been committed.
// Reset: asynchronous, active low; empties the store and sets capacity to 8.
module lru_key_value_cache_unit #(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    lkvc_in_if.sink     req,
    lkvc_out_if.source  rsp,
    lkvc_cfg_if.sink    cfg
);
    import lkvc_pkg::*;

    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    state_t                state_reg;
    state_t                state_next;
    cmd_t                  op_cmd_reg;
    logic [KEY_BITS-1:0]   op_key_reg;
    logic [VALUE_BITS-1:0] op_value_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CAP_W-1:0]      cap_reg;
    logic                  rsp_valid_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] rv_reg;
    logic [OCC_W-1:0]      occ_reg;

    logic                  req_ready;
    logic                  commit;
    logic                  is_get;
    logic                  is_ins;
    logic                  hit_any;
    logic                  evict;
    logic [CW-1:0]         c1;
    logic [CW-1:0]         c2;
    logic [CW-1:0]         new_top;
    logic [CMPW-1:0]       eff_cap;
    logic [VALUE_BITS-1:0] cell_value;
    logic [VALUE_BITS-1:0] rv_out;
    cell_ctrl_t            ctrl;

    logic [ENTRIES:0]      seen_chain;
    logic [VALUE_BITS-1:0] rv_chain [ENTRIES+1];
    logic [KEY_BITS-1:0]   key_q    [ENTRIES];
    logic [VALUE_BITS-1:0] value_q  [ENTRIES];

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (req.valid) state_next = ST_EXEC;
            ST_EXEC:
                if (commit) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        req_ready = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            ST_IDLE: req_ready = 1'b1;
            ST_EXEC: commit    = !rsp_valid_reg || rsp.ready;
            default: req_ready = 1'b0;
        endcase
    end

    assign req.ready = req_ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (req.valid && req_ready)
        begin
            op_cmd_reg   <= cmd_t'(req.cmd);
            op_key_reg   <= req.key;
            op_value_reg <= req.value;
        end
    end

    // capacity clamped to 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CMPW'(1);
        else if (CMPW'(cap_reg) > CMPW'(ENTRIES))
            eff_cap = CMPW'(ENTRIES);
        else
            eff_cap = CMPW'(cap_reg);
    end

    // occupancy bookkeeping and row control
    assign is_get  = (op_cmd_reg == CMD_GET);
    assign is_ins  = (op_cmd_reg == CMD_INSERT);
    assign hit_any = seen_chain[ENTRIES];
    assign c1      = count_reg - CW'(hit_any);
    assign evict   = is_ins && (c1 != '0) && (CMPW'(c1) >= eff_cap);
    assign c2      = c1 - CW'(evict);

    always_comb
    begin
        count_next = count_reg;
        new_top    = count_reg - CW'(1);
        case (op_cmd_reg)
            CMD_GET:
            begin
                count_next = count_reg;
                new_top    = count_reg - CW'(1);
            end
            CMD_INSERT:
            begin
                count_next = c2 + CW'(1);
                new_top    = c2;
            end
            CMD_CLEAR:
                count_next = '0;
            default:
                count_next = count_reg;
        endcase
    end

    assign ctrl.update = commit && ((is_get && hit_any) || is_ins);
    assign ctrl.evict  = evict;
    assign ctrl.hit    = hit_any;

    assign rv_out     = is_get ? rv_chain[ENTRIES] : '0;
    assign cell_value = is_get ? rv_chain[ENTRIES] : op_value_reg;

    // row of cells, oldest at index 0
    assign seen_chain[0] = 1'b0;
    assign rv_chain[0]   = '0;

    for (genvar gi = 0; gi < ENTRIES; gi++)
    begin : g_cell
        localparam int U1 = (gi + 1 < ENTRIES) ? gi + 1 : gi;
        localparam int U2 = (gi + 2 < ENTRIES) ? gi + 2 : gi;
        localparam int SU = (gi + 1 < ENTRIES) ? gi + 2 : gi + 1;

        lkvc_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (count_reg > CW'(gi)),
            .load       (new_top == CW'(gi)),
            .lookup_key (op_key_reg),
            .new_value  (cell_value),
            .up1_key    (key_q[U1]),
            .up1_value  (value_q[U1]),
            .up2_key    (key_q[U2]),
            .up2_value  (value_q[U2]),
            .seen_in    (seen_chain[gi]),
            .seen_up    (seen_chain[SU]),
            .rv_in      (rv_chain[gi]),
            .seen_out   (seen_chain[gi+1]),
            .rv_out     (rv_chain[gi+1]),
            .key_q      (key_q[gi]),
            .value_q    (value_q[gi])
        );
    end

    // occupancy and capacity registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            if (commit)
                count_reg <= count_next;
            if (cfg.valid)
                cap_reg <= cfg.data;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (commit)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            hit_reg <= hit_any && (is_get || is_ins);
            rv_reg  <= rv_out;
            occ_reg <= OCC_W'(count_next);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = hit_reg;
    assign rsp.read_value = rv_reg;
    assign rsp.occupancy  = occ_reg;

endmodule

// ----- design/lkvc_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks on the cache unit
module lkvc_checker #(
    parameter int VALUE_BITS = 64
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       rsp_hit,
    input logic [VALUE_BITS-1:0]      rsp_read_value,
    input logic [lkvc_pkg::OCC_W-1:0] rsp_occupancy
);
    import lkvc_pkg::*;

    // a result word is held until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped before it was taken");

    // a stalled result word keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(rsp_hit) && $stable(rsp_read_value) && $stable(rsp_occupancy))
        else $error("result word changed while stalled");

    // one operation at a time: no request taken in the cycle after one was
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an operation is in flight");

    // only a lookup hit returns data
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_read_value == '0)
        else $error("non-zero read value without a hit");

endmodule

bind lru_key_value_cache_unit lkvc_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_read_value (rsp.read_value),
    .rsp_occupancy  (rsp.occupancy)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lkvc_pkg::*;

    localparam int ENTRIES     = 8;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 64;
    localparam int PHASE_ITEMS = 148;
    localparam int PHASES      = 9;
    localparam int HOLD_CYCLES = 80;
    localparam int DIRECTED_N  = 20;

    // Capacity for each random phase; no clear in between, so lowering
    // the capacity meets a store that is already fuller than allowed
    localparam logic [CAP_W-1:0] CAP_PLAN [PHASES] =
        '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd9, 4'd5, 4'd2, 4'd8};

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic [OCC_W-1:0]      occupancy;
    } lru_result_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic                  typed;
        lru_result_t           want;
    } directed_row_t;

    // Opening sequence at the reset capacity of 8; rows with typed = 0
    // are checked against the recency model
    localparam directed_row_t DIRECTED [DIRECTED_N] = '{
        '{CMD_GET,    32'h0000_0000, 64'h0,                   1'b1, '{1'b0, 64'h0, 4'd0}},
        '{CMD_NOP,    32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'h0, 4'd0}},
        '{CMD_INSERT, 32'h0000_0000, 64'h0,                   1'b1, '{1'b0, 64'h0, 4'd1}},
        '{CMD_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'h0, 4'd2}},
        '{CMD_GET,    32'hFFFF_FFFF, 64'h0,                   1'b1,
          '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd2}},
        '{CMD_GET,    32'h0000_0000, 64'h1234,                1'b1, '{1'b1, 64'h0, 4'd2}},
        '{CMD_INSERT, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555, 1'b1, '{1'b1, 64'h0, 4'd2}},
        '{CMD_GET,    32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{1'b1, 64'h5555_5555_5555_5555, 4'd2}},
        '{CMD_INSERT, 32'h0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{1'b0, 64'h0, 4'd3}},
        '{CMD_INSERT, 32'h0000_0002, 64'h0123_4567_89AB_CDEF, 1'b1, '{1'b0, 64'h0, 4'd4}},
        '{CMD_INSERT, 32'h0000_0003, 64'h8000_0000_0000_0000, 1'b1, '{1'b0, 64'h0, 4'd5}},
        '{CMD_INSERT, 32'h0000_0004, 64'h0000_0000_0000_0001, 1'b1, '{1'b0, 64'h0, 4'd6}},
        '{CMD_INSERT, 32'h0000_0005, 64'hFEDC_BA98_7654_3210, 1'b1, '{1'b0, 64'h0, 4'd7}},
        '{CMD_INSERT, 32'h0000_0006, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'h0, 4'd8}},
        '{CMD_INSERT, 32'h0000_0007, 64'h0000_0000_FFFF_FFFF, 1'b0, '0},
        '{CMD_GET,    32'h0000_0000, 64'h0,                   1'b0, '0},
        '{CMD_GET,    32'h0000_0001, 64'h0,                   1'b0, '0},
        '{CMD_NOP,    32'h0000_0001, 64'h0,                   1'b0, '0},
        '{CMD_CLEAR,  32'h0000_0003, 64'h0,                   1'b1, '{1'b0, 64'h0, 4'd0}},
        '{CMD_GET,    32'h0000_0003, 64'h0,                   1'b1, '{1'b0, 64'h0, 4'd0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    lkvc_in_if  #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_ch ();
    lkvc_out_if #(.VALUE_BITS(VALUE_BITS))                      rsp_ch ();
    lkvc_cfg_if                                                 cfg_ch ();

    lru_key_value_cache_unit #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Recency-ordered copy of the store: slot 0 oldest
    logic [KEY_BITS-1:0]   lru_keys [ENTRIES];
    logic [VALUE_BITS-1:0] lru_vals [ENTRIES];
    int unsigned           lru_count;
    logic [CAP_W-1:0]      lru_capacity;

    lru_result_t expected_results [$];
    int          fail_count;
    int          words_sent;
    int          get_hits;
    int          insert_updates;
    int          evictions;
    bit          no_gaps;
    bit          hold_pending;

    // Close the gap at pos, shifting newer entries down
    function automatic void drop_slot(int unsigned pos);
        for (int unsigned i = pos; i + 1 < lru_count; i++)
        begin
            lru_keys[i] = lru_keys[i + 1];
            lru_vals[i] = lru_vals[i + 1];
        end
        lru_count--;
    endfunction

    // Newest slot holding k, or -1
    function automatic int find_slot(logic [KEY_BITS-1:0] k);
        for (int i = int'(lru_count) - 1; i >= 0; i--)
            if (lru_keys[i] == k)
                return i;
        return -1;
    endfunction

    function automatic lru_result_t lru_apply(cmd_t op, logic [KEY_BITS-1:0] k,
                                              logic [VALUE_BITS-1:0] v);
        lru_result_t r;
        int          pos;
        int unsigned limit;
        r = '0;
        // zero acts as one, anything above the row size saturates
        limit = (lru_capacity == 0) ? 1 :
                (lru_capacity > ENTRIES) ? ENTRIES : int'(lru_capacity);
        case (op)
            CMD_GET:
            begin
                pos = find_slot(k);
                if (pos >= 0)
                begin
                    r.hit        = 1'b1;
                    r.read_value = lru_vals[pos];
                    drop_slot(pos);
                    lru_keys[lru_count] = k;
                    lru_vals[lru_count] = r.read_value;
                    lru_count++;
                end
            end
            CMD_INSERT:
            begin
                pos = find_slot(k);
                if (pos >= 0)
                begin
                    r.hit = 1'b1;
                    drop_slot(pos);
                end
                // only the single oldest leaves, even when over capacity
                if (lru_count > 0 && lru_count >= limit)
                begin
                    drop_slot(0);
                    evictions++;
                end
                lru_keys[lru_count] = k;
                lru_vals[lru_count] = v;
                lru_count++;
            end
            CMD_CLEAR:
                lru_count = 0;
            default:
                ;
        endcase
        r.occupancy = lru_count[OCC_W-1:0];
        return r;
    endfunction

    // Sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Offer one request word from the falling edge and predict on acceptance
    task automatic send_op(input cmd_t op, input logic [KEY_BITS-1:0] k,
                           input logic [VALUE_BITS-1:0] v,
                           input logic typed, input lru_result_t typed_want);
        int          gap;
        lru_result_t predicted;
        lru_result_t queued;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= op;
        req_ch.key   <= k;
        req_ch.value <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = lru_apply(op, k, v);
        if (predicted.hit && op == CMD_GET)
            get_hits++;
        if (predicted.hit && op == CMD_INSERT)
            insert_updates++;
        queued = typed ? typed_want : predicted;
        expected_results = {expected_results, queued};
        words_sent++;
        @(negedge clk);
    endtask

    // Capacity write, only once every outstanding result has come back
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        lru_capacity = cap;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result sink: random stalls, plus one long hold-off on request
    initial
    begin
        int r;
        int run;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    rsp_ch.ready <= 1'b1;
                    run = $urandom_range(1, 8);
                end
                else if (r < 72)
                begin
                    rsp_ch.ready <= 1'b1;
                    run = $urandom_range(20, 40);
                end
                else if (r < 95)
                begin
                    rsp_ch.ready <= 1'b0;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    run = $urandom_range(8, 25);
                end
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        lru_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected word: hit %0b read_value %h occupancy %0d",
                         $time, rsp_ch.hit, rsp_ch.read_value, rsp_ch.occupancy);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_ch.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b",
                             $time, want.hit, rsp_ch.hit);
                    fail_count++;
                end
                if (rsp_ch.read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, rsp_ch.read_value);
                    fail_count++;
                end
                if (rsp_ch.occupancy !== want.occupancy)
                begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, rsp_ch.occupancy);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [KEY_BITS-1:0]   key_pool [16];
        int                    pool_n;
        int                    r;
        cmd_t                  op;
        logic [KEY_BITS-1:0]   k;
        logic [VALUE_BITS-1:0] v;

        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = CMD_NOP;
        req_ch.key     = '0;
        req_ch.value   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        fail_count     = 0;
        words_sent     = 0;
        get_hits       = 0;
        insert_updates = 0;
        evictions      = 0;
        no_gaps        = 1'b0;
        hold_pending   = 1'b0;
        lru_count      = 0;
        lru_capacity   = CAP_RESET;
        for (int i = 0; i < ENTRIES; i++)
        begin
            lru_keys[i] = '0;
            lru_vals[i] = '0;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table at the reset capacity
        for (int i = 0; i < DIRECTED_N; i++)
            send_op(DIRECTED[i].cmd, DIRECTED[i].key, DIRECTED[i].value,
                    DIRECTED[i].typed, DIRECTED[i].want);

        // Random phases, one capacity each
        for (int p = 0; p < PHASES; p++)
        begin
            set_capacity(CAP_PLAN[p]);
            no_gaps = (p == 2 || p == 5);
            if (p == 2)
            begin
                // long receiver hold-off while requests keep coming
                @(posedge clk);
                hold_pending = 1'b1;
                @(negedge clk);
            end
            pool_n = $urandom_range(3, 14);
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int i = 2; i < 16; i++)
                key_pool[i] = $urandom();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r  = $urandom_range(0, 99);
                op = (r < 45) ? CMD_GET : (r < 90) ? CMD_INSERT :
                     (r < 93) ? CMD_CLEAR : CMD_NOP;
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, pool_n - 1)];
                else
                    k = $urandom();
                r = $urandom_range(0, 99);
                if (r < 5)
                    v = '0;
                else if (r < 10)
                    v = '1;
                else
                    v = {$urandom(), $urandom()};
                send_op(op, k, v, 1'b0, '0);
            end
        end

        // Drain, then allow for the pipeline latency
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, expected_results.size());
            fail_count++;
        end

        $display("tb: %0d request words over %0d capacity settings incl. 0, 1, 8 and 15",
                 words_sent, PHASES + 1);
        $display("tb: %0d get hits, %0d insert updates, %0d evictions, %0d mismatches",
                 get_hits, insert_updates, evictions, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
